[rtl/core/evidence_grid_update_top_macros.svh]
// Assertion macros used by the evidence grid checker.
`ifndef EVIDENCE_GRID_UPDATE_TOP_MACROS_SVH
`define EVIDENCE_GRID_UPDATE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EGU_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EGU_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/egu_pkg.sv]
// Shared types, constants and codes of the evidence grid update block.
package egu_pkg;

    localparam int GRID_COLS = 256;
    localparam int GRID_ROWS = 256;
    localparam int CELL_MM   = 100;

    localparam int NCELLS = GRID_COLS * GRID_ROWS;
    localparam int IDX_W  = $clog2(NCELLS);
    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int SPAN_X = GRID_COLS * CELL_MM;
    localparam int SPAN_Y = GRID_ROWS * CELL_MM;

    // Division by the cell size is a multiply by a rounded-up reciprocal.
    localparam int    DIV_SH = 20 + $clog2(CELL_MM);
    localparam longint RECIP = ((64'd1 << DIV_SH) + CELL_MM - 1) / CELL_MM;

    localparam logic [15:0] K_KEEP      = 16'd58982;
    localparam logic [15:0] K_NEW       = 16'd6553;
    localparam logic [15:0] K_VAR_DECAY = 16'd64225;
    localparam logic [16:0] ONE_Q16     = 17'd65536;

    localparam logic [15:0] RST_Z_MAX     = 16'd2000;
    localparam logic [15:0] RST_OCC_THR   = 16'd300;
    localparam logic [16:0] RST_OCC_STEP  = 17'd13107;
    localparam logic [16:0] RST_VIS_STEP  = 17'd6554;
    localparam logic [16:0] RST_OCC_DECAY = 17'd62259;
    localparam logic [16:0] RST_VIS_DECAY = 17'd62259;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [1:0] {
        CMD_DECAY     = 2'd0,
        CMD_INTEGRATE = 2'd1,
        CMD_READ      = 2'd2,
        CMD_NONE      = 2'd3
    } cmd_e;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_Z_MAX     = 3'd2,
        CFG_OCC_THR   = 3'd3,
        CFG_OCC_STEP  = 3'd4,
        CFG_VIS_STEP  = 3'd5,
        CFG_OCC_DECAY = 3'd6,
        CFG_VIS_DECAY = 3'd7
    } cfg_idx_e;

    typedef enum logic [1:0] {
        RES_DROP = 2'd0,
        RES_ACK  = 2'd1,
        RES_CELL = 2'd2,
        RES_NEW  = 2'd3
    } res_sel_e;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_LOOKUP,
        ST_DATA,
        ST_CALC,
        ST_WRITE,
        ST_DEC_RD,
        ST_DEC_MUL,
        ST_DEC_WR
    } state_e;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [19:0] x_mm;
        logic signed [19:0] y_mm;
        logic signed [19:0] z_mm;
        logic [7:0]         read_col;
        logic [7:0]         read_row;
    } cmd_word_t;

    typedef struct packed {
        logic        accepted;
        logic [15:0] cell_height_mm;
        logic [16:0] occ_score;
        logic [16:0] vis_score;
        logic [31:0] variance_mm2;
        logic [15:0] point_count;
    } result_t;

    typedef struct packed {
        logic [15:0] height;
        logic [16:0] occ;
        logic [16:0] vis;
        logic [31:0] var_mm2;
        logic [15:0] cnt;
    } cell_t;

    typedef struct packed {
        logic     cap;
        logic     idx_en;
        logic     rd_cell;
        logic     rd_sweep;
        logic     calc1;
        logic     calc2;
        logic     int_wr;
        logic     dec_calc;
        logic     dec_wr;
        logic     clr_wr;
        logic     sweep_clr;
        logic     sweep_inc;
        logic     emit;
        res_sel_e res;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       ok;
        logic       sweep_last;
    } dp_stat_t;

endpackage

[rtl/core/egu_ctrl.sv]
// Sequencing state machine of the evidence grid update block.
module egu_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  egu_pkg::dp_stat_t stat,
    output egu_pkg::dp_cmd_t  ctl,
    output logic              busy
);

    egu_pkg::state_e state_reg;
    egu_pkg::state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= egu_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            egu_pkg::ST_CLEAR:
            begin
                if (stat.sweep_last)
                begin
                    state_next = egu_pkg::ST_IDLE;
                end
            end
            egu_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = egu_pkg::ST_DECODE;
                end
            end
            egu_pkg::ST_DECODE:
            begin
                if (stat.cmd == egu_pkg::CMD_DECAY)
                begin
                    state_next = egu_pkg::ST_DEC_RD;
                end
                else if (stat.cmd == egu_pkg::CMD_INTEGRATE || stat.cmd == egu_pkg::CMD_READ)
                begin
                    state_next = egu_pkg::ST_LOOKUP;
                end
                else
                begin
                    state_next = egu_pkg::ST_IDLE;
                end
            end
            egu_pkg::ST_LOOKUP:
            begin
                state_next = stat.ok ? egu_pkg::ST_DATA : egu_pkg::ST_IDLE;
            end
            egu_pkg::ST_DATA:
            begin
                state_next = (stat.cmd == egu_pkg::CMD_READ) ? egu_pkg::ST_IDLE
                                                             : egu_pkg::ST_CALC;
            end
            egu_pkg::ST_CALC:    state_next = egu_pkg::ST_WRITE;
            egu_pkg::ST_WRITE:   state_next = egu_pkg::ST_IDLE;
            egu_pkg::ST_DEC_RD:  state_next = egu_pkg::ST_DEC_MUL;
            egu_pkg::ST_DEC_MUL: state_next = egu_pkg::ST_DEC_WR;
            egu_pkg::ST_DEC_WR:
            begin
                state_next = stat.sweep_last ? egu_pkg::ST_IDLE : egu_pkg::ST_DEC_RD;
            end
            default:             state_next = egu_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl  = '0;
        busy = (state_reg != egu_pkg::ST_IDLE);
        case (state_reg)
            egu_pkg::ST_CLEAR:
            begin
                ctl.clr_wr    = 1'b1;
                ctl.sweep_inc = 1'b1;
            end
            egu_pkg::ST_IDLE:
            begin
                ctl.cap = start;
            end
            egu_pkg::ST_DECODE:
            begin
                ctl.idx_en = 1'b1;
                if (stat.cmd == egu_pkg::CMD_DECAY)
                begin
                    ctl.sweep_clr = 1'b1;
                end
                else if (stat.cmd != egu_pkg::CMD_INTEGRATE && stat.cmd != egu_pkg::CMD_READ)
                begin
                    ctl.emit = 1'b1;
                    ctl.res  = egu_pkg::RES_DROP;
                end
            end
            egu_pkg::ST_LOOKUP:
            begin
                if (stat.ok)
                begin
                    ctl.rd_cell = 1'b1;
                end
                else
                begin
                    ctl.emit = 1'b1;
                    ctl.res  = egu_pkg::RES_DROP;
                end
            end
            egu_pkg::ST_DATA:
            begin
                if (stat.cmd == egu_pkg::CMD_READ)
                begin
                    ctl.emit = 1'b1;
                    ctl.res  = egu_pkg::RES_CELL;
                end
                else
                begin
                    ctl.calc1 = 1'b1;
                end
            end
            egu_pkg::ST_CALC:
            begin
                ctl.calc2 = 1'b1;
            end
            egu_pkg::ST_WRITE:
            begin
                ctl.int_wr = 1'b1;
                ctl.emit   = 1'b1;
                ctl.res    = egu_pkg::RES_NEW;
            end
            egu_pkg::ST_DEC_RD:
            begin
                ctl.rd_sweep = 1'b1;
            end
            egu_pkg::ST_DEC_MUL:
            begin
                ctl.dec_calc = 1'b1;
            end
            egu_pkg::ST_DEC_WR:
            begin
                ctl.dec_wr = 1'b1;
                if (stat.sweep_last)
                begin
                    ctl.emit = 1'b1;
                    ctl.res  = egu_pkg::RES_ACK;
                end
                else
                begin
                    ctl.sweep_inc = 1'b1;
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

[rtl/core/egu_dp.sv]
// Datapath of the evidence grid update block: settings, cell memory and arithmetic.
module egu_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  egu_pkg::cmd_word_t                  command,
    input  logic                                cfg_we,
    input  logic [egu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [egu_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  egu_pkg::dp_cmd_t                    ctl,
    output egu_pkg::dp_stat_t                   stat,
    output logic                                done,
    output egu_pkg::result_t                    result
);

    logic [19:0] ox_reg;
    logic [19:0] oy_reg;
    logic [15:0] zmax_reg;
    logic [15:0] thr_reg;
    logic [16:0] ostep_reg;
    logic [16:0] vstep_reg;
    logic [16:0] odecay_reg;
    logic [16:0] vdecay_reg;

    logic [1:0]  cmd_reg;
    logic [20:0] dx_reg;
    logic [20:0] dy_reg;
    logic [15:0] zc_reg;
    logic [7:0]  rcol_reg;
    logic [7:0]  rrow_reg;

    logic [egu_pkg::IDX_W-1:0] idx_reg;
    logic                      ok_reg;
    logic [egu_pkg::IDX_W-1:0] ptr_reg;

    egu_pkg::cell_t mem [egu_pkg::NCELLS];
    egu_pkg::cell_t rdata_reg;
    egu_pkg::cell_t new_reg;
    egu_pkg::cell_t dec_reg;
    logic [31:0]    d2_reg;
    logic [47:0]    vkeep_reg;

    logic             done_reg;
    egu_pkg::result_t result_reg;

    // Settings.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ox_reg     <= '0;
            oy_reg     <= '0;
            zmax_reg   <= egu_pkg::RST_Z_MAX;
            thr_reg    <= egu_pkg::RST_OCC_THR;
            ostep_reg  <= egu_pkg::RST_OCC_STEP;
            vstep_reg  <= egu_pkg::RST_VIS_STEP;
            odecay_reg <= egu_pkg::RST_OCC_DECAY;
            vdecay_reg <= egu_pkg::RST_VIS_DECAY;
        end
        else if (cfg_we)
        begin
            case (egu_pkg::cfg_idx_e'(cfg_index))
                egu_pkg::CFG_ORIGIN_X:  ox_reg     <= cfg_data;
                egu_pkg::CFG_ORIGIN_Y:  oy_reg     <= cfg_data;
                egu_pkg::CFG_Z_MAX:     zmax_reg   <= cfg_data[15:0];
                egu_pkg::CFG_OCC_THR:   thr_reg    <= cfg_data[15:0];
                egu_pkg::CFG_OCC_STEP:  ostep_reg  <= cfg_data[16:0];
                egu_pkg::CFG_VIS_STEP:  vstep_reg  <= cfg_data[16:0];
                egu_pkg::CFG_OCC_DECAY: odecay_reg <= cfg_data[16:0];
                egu_pkg::CFG_VIS_DECAY: vdecay_reg <= cfg_data[16:0];
                default:                ox_reg     <= ox_reg;
            endcase
        end
    end

    // Capture: offsets from the origin and the clamped height.
    logic [15:0] zc_next;
    always_comb
    begin
        if (command.z_mm[19])
        begin
            zc_next = '0;
        end
        else if (command.z_mm[18:0] > {3'b000, zmax_reg})
        begin
            zc_next = zmax_reg;
        end
        else
        begin
            zc_next = command.z_mm[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap)
        begin
            cmd_reg  <= command.cmd;
            dx_reg   <= {command.x_mm[19], command.x_mm} - {ox_reg[19], ox_reg};
            dy_reg   <= {command.y_mm[19], command.y_mm} - {oy_reg[19], oy_reg};
            zc_reg   <= zc_next;
            rcol_reg <= command.read_col;
            rrow_reg <= command.read_row;
        end
    end

    // Cell index and bounds check.
    logic [63:0]               qx;
    logic [63:0]               qy;
    logic                      in_grid;
    logic                      rd_ok;
    logic [egu_pkg::IDX_W-1:0] pt_idx;
    logic [egu_pkg::IDX_W-1:0] rd_idx;
    always_comb
    begin
        qx = (64'(dx_reg[19:0]) * 64'(egu_pkg::RECIP)) >> egu_pkg::DIV_SH;
        qy = (64'(dy_reg[19:0]) * 64'(egu_pkg::RECIP)) >> egu_pkg::DIV_SH;
        in_grid = !dx_reg[20] && !dy_reg[20]
               && (32'(dx_reg[19:0]) < egu_pkg::SPAN_X)
               && (32'(dy_reg[19:0]) < egu_pkg::SPAN_Y);
        rd_ok  = (32'(rcol_reg) < egu_pkg::GRID_COLS) && (32'(rrow_reg) < egu_pkg::GRID_ROWS);
        pt_idx = egu_pkg::IDX_W'(32'(qy[egu_pkg::ROW_W-1:0]) * egu_pkg::GRID_COLS
                                 + 32'(qx[egu_pkg::COL_W-1:0]));
        rd_idx = egu_pkg::IDX_W'(32'(rrow_reg) * egu_pkg::GRID_COLS + 32'(rcol_reg));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.idx_en)
        begin
            if (cmd_reg == egu_pkg::CMD_READ)
            begin
                idx_reg <= rd_idx;
                ok_reg  <= rd_ok;
            end
            else
            begin
                idx_reg <= pt_idx;
                ok_reg  <= in_grid;
            end
        end
    end

    // Sweep pointer for clearing and frame decay.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (ctl.sweep_clr)
        begin
            ptr_reg <= '0;
        end
        else if (ctl.sweep_inc)
        begin
            ptr_reg <= ptr_reg + 1'b1;
        end
    end

    // Cell memory, one write and one registered read per cycle.
    logic                      mem_we;
    logic [egu_pkg::IDX_W-1:0] mem_waddr;
    egu_pkg::cell_t            mem_wdata;
    always_comb
    begin
        mem_we    = ctl.clr_wr || ctl.int_wr || ctl.dec_wr;
        mem_waddr = ctl.int_wr ? idx_reg : ptr_reg;
        if (ctl.int_wr)
        begin
            mem_wdata = new_reg;
        end
        else if (ctl.dec_wr)
        begin
            mem_wdata = dec_reg;
        end
        else
        begin
            mem_wdata = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (ctl.rd_cell || ctl.rd_sweep)
        begin
            rdata_reg <= mem[ctl.rd_cell ? idx_reg : ptr_reg];
        end
    end

    // Integrate, first step: height, scores, count, squared delta.
    logic [15:0] delta;
    logic [17:0] vis_sum;
    logic [17:0] occ_sum;
    logic [15:0] occ_dec;
    always_comb
    begin
        delta   = (zc_reg >= rdata_reg.height) ? zc_reg - rdata_reg.height
                                               : rdata_reg.height - zc_reg;
        vis_sum = 18'(rdata_reg.vis) + 18'(vstep_reg);
        occ_sum = 18'(rdata_reg.occ) + 18'(ostep_reg);
        occ_dec = ostep_reg[16:1];
    end

    // Integrate, second step: variance moving average.
    logic [48:0] var_sum;
    always_comb
    begin
        var_sum = 49'(vkeep_reg) + 49'(d2_reg) * 49'(egu_pkg::K_NEW);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.calc1)
        begin
            d2_reg         <= 32'(delta) * 32'(delta);
            vkeep_reg      <= 48'(rdata_reg.var_mm2) * 48'(egu_pkg::K_KEEP);
            new_reg.height <= (zc_reg > rdata_reg.height) ? zc_reg : rdata_reg.height;
            new_reg.vis    <= (vis_sum > 18'(egu_pkg::ONE_Q16)) ? egu_pkg::ONE_Q16
                                                                : vis_sum[16:0];
            new_reg.cnt    <= (rdata_reg.cnt == 16'hFFFF) ? rdata_reg.cnt
                                                          : rdata_reg.cnt + 16'd1;
            if (zc_reg >= thr_reg)
            begin
                new_reg.occ <= (occ_sum > 18'(egu_pkg::ONE_Q16)) ? egu_pkg::ONE_Q16
                                                                 : occ_sum[16:0];
            end
            else
            begin
                new_reg.occ <= (rdata_reg.occ > 17'(occ_dec)) ? rdata_reg.occ - 17'(occ_dec)
                                                              : 17'd0;
            end
        end
        if (ctl.calc2)
        begin
            new_reg.var_mm2 <= var_sum[48] ? 32'hFFFF_FFFF : var_sum[47:16];
        end
    end

    // Frame decay of one cell.
    logic [32:0] h_prod;
    logic [33:0] o_prod;
    logic [33:0] v_prod;
    logic [47:0] var_prod;
    always_comb
    begin
        h_prod   = 33'(rdata_reg.height) * 33'(odecay_reg);
        o_prod   = 34'(rdata_reg.occ) * 34'(odecay_reg);
        v_prod   = 34'(rdata_reg.vis) * 34'(vdecay_reg);
        var_prod = 48'(rdata_reg.var_mm2) * 48'(egu_pkg::K_VAR_DECAY);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.dec_calc)
        begin
            dec_reg.height  <= h_prod[32] ? 16'hFFFF : h_prod[31:16];
            dec_reg.occ     <= (o_prod[33:16] > 18'(egu_pkg::ONE_Q16)) ? egu_pkg::ONE_Q16
                                                                       : o_prod[32:16];
            dec_reg.vis     <= (v_prod[33:16] > 18'(egu_pkg::ONE_Q16)) ? egu_pkg::ONE_Q16
                                                                       : v_prod[32:16];
            dec_reg.var_mm2 <= var_prod[47:16];
            dec_reg.cnt     <= rdata_reg.cnt;
        end
    end

    // Result word.
    egu_pkg::result_t result_next;
    always_comb
    begin
        result_next = '0;
        case (ctl.res)
            egu_pkg::RES_DROP:
            begin
                result_next = '0;
            end
            egu_pkg::RES_ACK:
            begin
                result_next.accepted = 1'b1;
            end
            egu_pkg::RES_CELL:
            begin
                result_next = {1'b1, rdata_reg.height, rdata_reg.occ, rdata_reg.vis,
                               rdata_reg.var_mm2, rdata_reg.cnt};
            end
            egu_pkg::RES_NEW:
            begin
                result_next = {1'b1, new_reg.height, new_reg.occ, new_reg.vis,
                               new_reg.var_mm2, new_reg.cnt};
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign stat.cmd        = cmd_reg;
    assign stat.ok         = ok_reg;
    assign stat.sweep_last = (ptr_reg == egu_pkg::IDX_W'(egu_pkg::NCELLS - 1));
    assign done            = done_reg;
    assign result          = result_reg;

endmodule

[rtl/core/evidence_grid_update_top.sv]
// Top level of the evidence grid update block.
// Steps of a command: an integrate passes decode, lookup, data, calc and write; a read ends
// in data, a dropped point in lookup, an unused command in decode; frame decay runs one read,
// scale and write per cell. One word is in work at a time and busy falls as its result shows,
// so a new word is taken only once the last one is through; the receiver never stalls.
// After reset busy stays high while the cells clear; registers take defaults.
module evidence_grid_update_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  egu_pkg::cmd_word_t             command,
    output logic                           busy,
    output logic                           done,
    output egu_pkg::result_t               result,
    input  logic                           cfg_we,
    input  logic [egu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [egu_pkg::CFG_DATA_W-1:0] cfg_data
);

    // The controller sequences each command through the datapath; the two
    // sides meet only through the command and status structs below.
    egu_pkg::dp_cmd_t  ctl;
    egu_pkg::dp_stat_t stat;

    egu_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    // The datapath holds the configuration registers, the cell memory and the
    // arithmetic, and registers the result word with a one-cycle done strobe when a command
    // finishes. Configuration writes belong in cycles where busy is low.
    egu_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (command),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

endmodule

[rtl/core/egu_checker.sv]
// Port-level checker of the evidence grid update block and its binding.
`include "evidence_grid_update_top_macros.svh"

module egu_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input egu_pkg::result_t result
);

    `EGU_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted word did not raise busy")
    `EGU_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy, "result shown while still busy")
    `EGU_ASSERT_NXT(a_done_single, clk, rst_n, done, !done, "result strobe lasted two cycles")
    `EGU_ASSERT_IMP(a_drop_zero, clk, rst_n, done && !result.accepted, result.variance_mm2 == 32'd0 && result.point_count == 16'd0 && result.cell_height_mm == 16'd0, "dropped result carries data")

endmodule

bind evidence_grid_update_top egu_checker u_chk
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
